// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is asserted
`define HSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define HSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsp_pkg
// Types and constants for the histogram spread per block unit.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int MAX_HALF_WIDTH = 1024;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QLVL_W         = $clog2(QDEPTH + 1);

  localparam logic [31:0] DIV_SCALE = 32'd10000;
  localparam logic [26:0] STD_MAX   = 27'h7FFFFFF;

  // register indexes on the config bus
  localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] REG_RUN_COUNT  = 2'd1;
  localparam logic [1:0] REG_TIME_STEP  = 2'd2;

  typedef struct packed {
    logic [10:0] half_width;
    logic [17:0] run_count;
    logic [15:0] time_step;
  } cfg_t;

  // finished block sums handed from front to back
  typedef struct packed {
    logic [63:0] s1;
    logic [63:0] s2;
    logic [31:0] idx;
  } blk_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ROOT,
    B_DIV,
    B_DONE
  } bstate_t;

  function automatic logic [10:0] eff_half(input logic [10:0] hw);
    logic [10:0] h;
    h = hw;
    if (hw == 11'd0) h = 11'd1;
    else if (hw > 11'(MAX_HALF_WIDTH)) h = 11'(MAX_HALF_WIDTH);
    return h;
  endfunction

endpackage

// ===== rtl/hsp_queue.sv =====
// ----------------------------------------------------------------------------
// hsp_queue
// Short FIFO of finished block sums between front and back.
// ----------------------------------------------------------------------------
module hsp_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  hsp_pkg::blk_t                  push_data,
  input  logic                           pop,
  output logic                           q_valid,
  output hsp_pkg::blk_t                  head,
  output logic [hsp_pkg::QLVL_W-1:0]     level
);
  import hsp_pkg::*;

  blk_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] lvl_r, lvl_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    lvl_nxt    = lvl_r + QLVL_W'(push) - QLVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign q_valid = (lvl_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign level   = lvl_r;

endmodule

// ===== rtl/hsp_front.sv =====
// ----------------------------------------------------------------------------
// hsp_front
// Takes bin counts, tracks position and position squared, and accumulates
// the first and second moment sums. Pushes the sums at block end.
// ----------------------------------------------------------------------------
module hsp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hsp_pkg::cfg_t               cfg,
  input  logic                        restart,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [23:0]                 in_bin_count,
  input  logic [hsp_pkg::QLVL_W-1:0]  q_level,
  output logic                        push,
  output hsp_pkg::blk_t               push_data
);
  import hsp_pkg::*;

  logic [10:0] eff;
  logic        accept;
  logic        is_last;
  logic        pend;

  logic signed [11:0] pos_r, pos_nxt;
  logic [20:0]        psq_r, psq_nxt;
  logic               prod_v_r, prod_v_nxt;
  logic               last_r, last_nxt;
  logic signed [36:0] p1_r, p1_nxt;
  logic [44:0]        p2_r, p2_nxt;
  logic [63:0]        s1_r, s1_nxt;
  logic [63:0]        s2_r, s2_nxt;
  logic [31:0]        idx_r, idx_nxt;
  logic [63:0]        s1_sum, s2_sum;
  logic [21:0]        hsq;
  logic [22:0]        psq_step;

  assign eff     = eff_half(cfg.half_width);
  assign pend    = prod_v_r & last_r;
  assign in_stall = ({1'b0, q_level} + {{QLVL_W{1'b0}}, pend}) >= (QLVL_W + 1)'(QDEPTH);
  assign accept  = in_valid & ~in_stall;
  assign is_last = ($signed({pos_r[11], pos_r}) + 13'sd1) >= $signed({2'b00, eff});

  assign hsq      = {11'd0, eff} * {11'd0, eff};
  // (p+1)^2 = p^2 + 2p + 1
  assign psq_step = {2'b00, psq_r} + {{10{pos_r[11]}}, pos_r, 1'b0} + 23'd1;

  assign s1_sum = s1_r + {{27{p1_r[36]}}, p1_r};
  assign s2_sum = s2_r + {19'd0, p2_r};

  assign push      = prod_v_r & last_r;
  assign push_data = '{s1: s1_sum, s2: s2_sum, idx: idx_r};

  always_comb begin
    pos_nxt    = pos_r;
    psq_nxt    = psq_r;
    prod_v_nxt = accept;
    last_nxt   = is_last;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    s1_nxt     = s1_r;
    s2_nxt     = s2_r;
    idx_nxt    = idx_r;

    if (accept) begin
      p1_nxt = pos_r * $signed({1'b0, in_bin_count});
      p2_nxt = {24'd0, psq_r} * {21'd0, in_bin_count};
      if (is_last) begin
        pos_nxt = -$signed({1'b0, eff});
        psq_nxt = hsq[20:0];
      end else begin
        pos_nxt = pos_r + 12'sd1;
        psq_nxt = psq_step[20:0];
      end
    end

    if (prod_v_r) begin
      if (last_r) begin
        s1_nxt  = '0;
        s2_nxt  = '0;
        idx_nxt = idx_r + 32'd1;
      end else begin
        s1_nxt = s1_sum;
        s2_nxt = s2_sum;
      end
    end

    // half width rewritten: user keeps to idle, empty pipe; not enforced
    if (restart) begin
      pos_nxt = -$signed({1'b0, eff});
      psq_nxt = hsq[20:0];
      s1_nxt  = '0;
      s2_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= -12'sd512;
      psq_r    <= 21'd262144;
      prod_v_r <= 1'b0;
      last_r   <= 1'b0;
      s1_r     <= '0;
      s2_r     <= '0;
      idx_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      psq_r    <= psq_nxt;
      prod_v_r <= prod_v_nxt;
      last_r   <= last_nxt;
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

endmodule

// ===== rtl/hsp_back.sv =====
// ----------------------------------------------------------------------------
// hsp_back
// Per block: forms S2*D - S1^2 with a shared 32x32 multiplier, takes the
// integer root of that value times 2^32, divides by D, holds the result.
// ----------------------------------------------------------------------------
module hsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  hsp_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  hsp_pkg::blk_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   out_time_stamp,
  output logic [26:0]   out_std_dev,
  output logic          out_negative_variance
);
  import hsp_pkg::*;

  bstate_t state_r, state_nxt;

  logic [63:0]  m1_r, m1_nxt;
  logic [63:0]  m2_r, m2_nxt;
  logic         n2_r, n2_nxt;
  logic [31:0]  d_r, d_nxt;
  logic [31:0]  stamp_r, stamp_nxt;
  logic [2:0]   step_r, step_nxt;
  logic         ph_r, ph_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [1:0]   sh_r, sh_nxt;
  logic         sub_r, sub_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [159:0] x_r, x_nxt;
  logic [81:0]  rem_r, rem_nxt;
  logic [79:0]  root_r, root_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [79:0]  dv_r, dv_nxt;
  logic [57:0]  dsh_r, dsh_nxt;
  logic [26:0]  q_r, q_nxt;
  logic [26:0]  std_r, std_nxt;
  logic         neg_r, neg_nxt;
  logic         ov_r, ov_nxt;
  logic [31:0]  ots_r, ots_nxt;
  logic [26:0]  osd_r, osd_nxt;
  logic         onv_r, onv_nxt;

  logic [31:0]  op_a, op_b;
  logic [127:0] pp_ext;
  logic [83:0]  rem2, trial;
  logic [17:0]  rc_eff;
  logic [47:0]  stamp_full;
  logic         slot_free;

  assign rc_eff     = (cfg.run_count == 18'd0) ? 18'd1 : cfg.run_count;
  assign stamp_full = head.idx * {16'd0, cfg.time_step};
  assign pp_ext     = {64'd0, pp_r} << {sh_r, 5'd0};
  assign rem2       = {rem_r, x_r[159:158]};
  assign trial      = {2'b00, root_r, 2'b01};
  assign slot_free  = ~ov_r | ~out_stall;

  always_comb begin
    case (step_r)
      3'd0:    begin op_a = m2_r[31:0];  op_b = d_r;         end
      3'd1:    begin op_a = m2_r[63:32]; op_b = d_r;         end
      3'd2:    begin op_a = m1_r[31:0];  op_b = m1_r[31:0];  end
      3'd3:    begin op_a = m1_r[31:0];  op_b = m1_r[63:32]; end
      3'd4:    begin op_a = m1_r[63:32]; op_b = m1_r[31:0];  end
      default: begin op_a = m1_r[63:32]; op_b = m1_r[63:32]; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    m1_nxt    = m1_r;
    m2_nxt    = m2_r;
    n2_nxt    = n2_r;
    d_nxt     = d_r;
    stamp_nxt = stamp_r;
    step_nxt  = step_r;
    ph_nxt    = ph_r;
    pp_nxt    = pp_r;
    sh_nxt    = sh_r;
    sub_nxt   = sub_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    dv_nxt    = dv_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    std_nxt   = std_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r & out_stall;
    ots_nxt   = ots_r;
    osd_nxt   = osd_r;
    onv_nxt   = onv_r;
    pop       = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          m1_nxt    = head.s1[63] ? (64'd0 - head.s1) : head.s1;
          m2_nxt    = head.s2[63] ? (64'd0 - head.s2) : head.s2;
          n2_nxt    = head.s2[63];
          d_nxt     = {14'd0, rc_eff} * DIV_SCALE;
          stamp_nxt = stamp_full[31:0];
          step_nxt  = 3'd0;
          ph_nxt    = 1'b0;
          acc_nxt   = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        if (!ph_r) begin
          pp_nxt  = op_a * op_b;
          sub_nxt = (step_r < 3'd2) ? n2_r : 1'b1;
          case (step_r)
            3'd0:    sh_nxt = 2'd0;
            3'd1:    sh_nxt = 2'd1;
            3'd2:    sh_nxt = 2'd0;
            3'd5:    sh_nxt = 2'd2;
            default: sh_nxt = 2'd1;
          endcase
          ph_nxt = 1'b1;
        end else begin
          acc_nxt  = sub_r ? (acc_r - pp_ext) : (acc_r + pp_ext);
          ph_nxt   = 1'b0;
          step_nxt = step_r + 3'd1;
          if (step_r == 3'd5) begin
            x_nxt     = {acc_nxt, 32'd0};
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = 7'd79;
            if (acc_nxt[127]) begin
              std_nxt   = '0;
              neg_nxt   = 1'b1;
              state_nxt = B_DONE;
            end else begin
              state_nxt = B_ROOT;
            end
          end
        end
      end
      B_ROOT: begin
        // two bits of the radicand per step
        x_nxt = {x_r[157:0], 2'b00};
        if (rem2 >= trial) begin
          rem_nxt  = 82'(rem2 - trial);
          root_nxt = {root_r[78:0], 1'b1};
        end else begin
          rem_nxt  = rem2[81:0];
          root_nxt = {root_r[78:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          dv_nxt    = root_nxt;
          dsh_nxt   = {d_r, 26'd0};
          q_nxt     = '0;
          cnt_nxt   = 7'd27;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt_r == 7'd27) begin
          // quotient would not fit in 27 bits
          if (dv_r >= {21'd0, d_r, 27'd0}) begin
            std_nxt   = STD_MAX;
            neg_nxt   = 1'b0;
            state_nxt = B_DONE;
          end else begin
            cnt_nxt = 7'd26;
          end
        end else begin
          if (dv_r >= {22'd0, dsh_r}) begin
            dv_nxt = dv_r - {22'd0, dsh_r};
            q_nxt  = {q_r[25:0], 1'b1};
          end else begin
            q_nxt  = {q_r[25:0], 1'b0};
          end
          dsh_nxt = {1'b0, dsh_r[57:1]};
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            std_nxt   = q_nxt;
            neg_nxt   = 1'b0;
            state_nxt = B_DONE;
          end
        end
      end
      B_DONE: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ots_nxt   = stamp_r;
          osd_nxt   = std_r;
          onv_nxt   = neg_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= m1_nxt;
    m2_r    <= m2_nxt;
    n2_r    <= n2_nxt;
    d_r     <= d_nxt;
    stamp_r <= stamp_nxt;
    step_r  <= step_nxt;
    ph_r    <= ph_nxt;
    pp_r    <= pp_nxt;
    sh_r    <= sh_nxt;
    sub_r   <= sub_nxt;
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    dv_r    <= dv_nxt;
    dsh_r   <= dsh_nxt;
    q_r     <= q_nxt;
    std_r   <= std_nxt;
    neg_r   <= neg_nxt;
    ots_r   <= ots_nxt;
    osd_r   <= osd_nxt;
    onv_r   <= onv_nxt;
  end

  assign out_valid             = ov_r;
  assign out_time_stamp        = ots_r;
  assign out_std_dev           = osd_r;
  assign out_negative_variance = onv_r;

endmodule

// ===== rtl/histogram_spread_per_block_unit.sv =====
// ----------------------------------------------------------------------------
// histogram_spread_per_block_unit
// Spread (standard deviation) of a histogram per block of bins.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   in_      | in  | in_valid/in_stall  | in_bin_count[23:0]
//   out_     | out | out_valid/out_stall| out_time_stamp, out_std_dev, out_negative_variance
//   cfg (APB)| in  | psel/penable/pready| paddr[3:0], pwdata, prdata
//
// Bins are taken one per cycle while the block queue (4 entries) has room.
// Each block end takes the back part through a pop, six products on the shared
// 32x32 multiplier, 80 root steps, 28 divide steps and the output load (no root
// or divide on a negative variance; the divide stops early when it saturates).
// Short blocks therefore fill the queue and raise in_stall until it drains.
// Reset (synchronous, active low) clears control; half width 512, run count 1,
// time step 1. out_stall holds the result register; the back part waits.
// ----------------------------------------------------------------------------
module histogram_spread_per_block_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_bin_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_time_stamp,
  output logic [26:0] out_std_dev,
  output logic        out_negative_variance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hsp_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  wr_en;
  logic  restart;
  logic  push, pop, q_valid;
  blk_t  push_data, head;
  logic [QLVL_W-1:0] q_level;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign restart = wr_en & (paddr[3:2] == REG_HALF_WIDTH);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_HALF_WIDTH: cfg_nxt.half_width = pwdata[10:0];
        REG_RUN_COUNT:  cfg_nxt.run_count  = pwdata[17:0];
        REG_TIME_STEP:  cfg_nxt.time_step  = pwdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HALF_WIDTH: prdata = {21'd0, cfg_r.half_width};
      REG_RUN_COUNT:  prdata = {14'd0, cfg_r.run_count};
      REG_TIME_STEP:  prdata = {16'd0, cfg_r.time_step};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{half_width: 11'd512, run_count: 18'd1, time_step: 16'd1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_nxt),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bin_count (in_bin_count),
    .q_level      (q_level),
    .push         (push),
    .push_data    (push_data)
  );

  hsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head),
    .level     (q_level)
  );

  hsp_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (q_valid),
    .head                  (head),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_time_stamp        (out_time_stamp),
    .out_std_dev           (out_std_dev),
    .out_negative_variance (out_negative_variance)
  );

endmodule

// ===== rtl/hsp_checker.sv =====
// ----------------------------------------------------------------------------
// hsp_port_props
// Port-level checks on the histogram spread per block unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsp_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_time_stamp,
  input logic [26:0] out_std_dev,
  input logic        out_negative_variance,
  input logic        pready
);

  logic        neg_out;
  logic [59:0] out_payload;

  assign neg_out     = out_valid && out_negative_variance;
  assign out_payload = {out_time_stamp, out_std_dev, out_negative_variance};

  `HSP_ASSERT_ALWAYS(a_no_out_after_reset, !rst_n |=> !out_valid, "result valid after reset")
  `HSP_ASSERT(a_neg_zero, neg_out |-> out_std_dev == '0, "negative variance, std_dev not zero")
  `HSP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_payload), "stalled result changed")
  `HSP_ASSERT(a_pready, pready, "pready low")

endmodule

bind histogram_spread_per_block_unit hsp_port_props u_hsp_port_props (.*);
